FILE: rtl/core/psrw_pkg.sv
// Shared types and constants for the packet sequence replay window tracker.
`default_nettype none

package psrw_pkg;

  // Field widths of one transfer.
  localparam int unsigned WIRE_SEQ_W = 16;
  localparam int unsigned FULL_SEQ_W = 64;
  localparam int unsigned ACK_SEQ_W  = 16;
  localparam int unsigned ACK_MASK_W = 32;

  // Command codes carried in s_tuser.
  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  // Sequence reconstruction constants: half span and full span of the wire field.
  localparam logic [FULL_SEQ_W-1:0] SEQ_HALF = 64'h0000_0000_0000_8000;
  localparam logic [FULL_SEQ_W-1:0] SEQ_SPAN = 64'h0000_0000_0001_0000;

  // One result item.
  typedef struct packed {
    logic [ACK_MASK_W-1:0] ack_mask;
    logic [ACK_SEQ_W-1:0]  ack_seq;
    logic                  is_new;
    logic [FULL_SEQ_W-1:0] full_seq;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/psrw_tracker.sv
// Sequence tracker state and the combinational update for one item.
`default_nettype none

module psrw_tracker #(
  parameter int unsigned WINDOW_BITS = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                en,
  input  wire logic                                command,
  input  wire logic [psrw_pkg::WIRE_SEQ_W-1:0]     wire_seq,
  output psrw_pkg::result_t                        res
);
  import psrw_pkg::*;

  localparam int unsigned DW = $clog2(WINDOW_BITS + 1);
  localparam int unsigned IW = $clog2(WINDOW_BITS);
  localparam logic [FULL_SEQ_W-1:0] WIN64 = FULL_SEQ_W'(WINDOW_BITS);
  localparam logic [WINDOW_BITS-1:0] ONE_BIT = WINDOW_BITS'(1);

  logic                    seen_any;
  logic [FULL_SEQ_W-1:0]   highest_seq;
  logic [WINDOW_BITS-1:0]  history_mask;

  logic                    seen_any_next;
  logic [FULL_SEQ_W-1:0]   highest_seq_next;
  logic [WINDOW_BITS-1:0]  history_mask_next;

  logic [FULL_SEQ_W-1:0]   cand;
  logic [FULL_SEQ_W-1:0]   ext_seq;
  logic [FULL_SEQ_W-1:0]   dist_fwd;
  logic [FULL_SEQ_W-1:0]   dist_back;
  logic [DW-1:0]           fwd_small;
  logic [DW-1:0]           back_small;
  logic [IW-1:0]           fwd_idx;
  logic [IW-1:0]           back_idx;
  logic [WINDOW_BITS-1:0]  back_bit;
  logic [FULL_SEQ_W-1:0]   seq;
  logic                    fresh;
  logic [ACK_MASK_W-1:0]   mask32;

  // Extend the wire value to the counter closest to the highest sequence.
  always_comb begin
    cand = {highest_seq[FULL_SEQ_W-1:WIRE_SEQ_W], wire_seq};
    if ((cand + SEQ_HALF) < highest_seq) begin
      ext_seq = cand + SEQ_SPAN;
    end else if ((cand > (highest_seq + SEQ_HALF)) && (cand >= SEQ_SPAN)) begin
      ext_seq = cand - SEQ_SPAN;
    end else begin
      ext_seq = cand;
    end
  end

  // Distances to the highest sequence in both directions.
  assign dist_fwd   = ext_seq - highest_seq;
  assign dist_back  = highest_seq - ext_seq;
  assign fwd_small  = dist_fwd[DW-1:0];
  assign back_small = dist_back[DW-1:0];
  assign fwd_idx    = IW'(fwd_small - DW'(1));
  assign back_idx   = IW'(back_small - DW'(1));
  assign back_bit   = ONE_BIT << back_idx;

  // State update and result for the current item.
  always_comb begin
    seen_any_next     = seen_any;
    highest_seq_next  = highest_seq;
    history_mask_next = history_mask;
    seq               = '0;
    fresh             = 1'b0;
    if (command == CMD_CLEAR) begin
      seen_any_next     = 1'b0;
      highest_seq_next  = '0;
      history_mask_next = '0;
    end else if (!seen_any) begin
      // First packet after a clear takes the wire value as is.
      seq               = FULL_SEQ_W'(wire_seq);
      seen_any_next     = 1'b1;
      highest_seq_next  = FULL_SEQ_W'(wire_seq);
      history_mask_next = '0;
      fresh             = 1'b1;
    end else if (ext_seq > highest_seq) begin
      // Newer packet: slide the window and mark the old highest.
      seq = ext_seq;
      if (dist_fwd >= WIN64) begin
        history_mask_next = '0;
      end else begin
        history_mask_next = history_mask << fwd_small;
      end
      if (dist_fwd <= WIN64) begin
        history_mask_next = history_mask_next | (ONE_BIT << fwd_idx);
      end
      highest_seq_next = ext_seq;
      fresh            = 1'b1;
    end else begin
      // Older packet or duplicate of the highest.
      seq = ext_seq;
      if ((dist_back != '0) && (dist_back <= WIN64)) begin
        fresh             = ((history_mask & back_bit) == '0);
        history_mask_next = history_mask | back_bit;
      end
    end
  end

  // Low bits of the window go out as the ack mask.
  generate
    if (WINDOW_BITS >= ACK_MASK_W) begin : g_mask_wide
      assign mask32 = history_mask_next[ACK_MASK_W-1:0];
    end else begin : g_mask_narrow
      assign mask32 = {{(ACK_MASK_W - WINDOW_BITS){1'b0}}, history_mask_next};
    end
  endgenerate

  assign res.full_seq = seq;
  assign res.is_new   = fresh;
  assign res.ack_seq  = highest_seq_next[ACK_SEQ_W-1:0];
  assign res.ack_mask = mask32;

  // Tracker state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_any     <= 1'b0;
      highest_seq  <= '0;
      history_mask <= '0;
    end else if (en) begin
      seen_any     <= seen_any_next;
      highest_seq  <= highest_seq_next;
      history_mask <= history_mask_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/packet_seq_replay_window_top.sv
// Top level: input register, sequence tracker and output register.
// An item sits in the input register, then its result in the output register
// that drives m_tvalid. Throughput: one item per cycle while m_tready does not
// stall the output; the tracker state updates in the same cycle that an item
// moves from the input register into the output register.
// Reset (rst, synchronous, active high) empties both registers and clears the
// tracker to no packet seen, highest sequence zero and an empty window.
`default_nettype none

module packet_seq_replay_window_top #(
  parameter int unsigned WINDOW_BITS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [15:0]  s_tdata,  // [15:0] wire_seq
  input  wire logic [0:0]   s_tuser,  // [0] command
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [111:0]      m_tdata,  // [63:0] full_seq, [79:64] ack_seq, [111:80] ack_mask
  output logic [0:0]        m_tuser   // [0] is_new
);
  import psrw_pkg::*;

  logic                   s0_valid;
  logic                   s0_cmd;
  logic [WIRE_SEQ_W-1:0]  s0_wire;
  logic                   advance;
  result_t                res;
  result_t                out_res;

  // The output register drains or is empty; the input register may then move.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !s0_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (s_tready) begin
      s0_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s0_cmd  <= s_tuser[0];
      s0_wire <= s_tdata;
    end
  end

  psrw_tracker #(
    .WINDOW_BITS(WINDOW_BITS)
  ) u_tracker (
    .clk      (clk),
    .rst      (rst),
    .en       (s0_valid && advance),
    .command  (s0_cmd),
    .wire_seq (s0_wire),
    .res      (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_valid && advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.ack_mask, out_res.ack_seq, out_res.full_seq};
  assign m_tuser = out_res.is_new;

endmodule

`default_nettype wire

FILE: rtl/core/psrw_checker.sv
// Port-level checks for the replay window top level, with its bind.
`default_nettype none

module psrw_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tready,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [111:0] m_tdata,
  input wire logic [0:0]   m_tuser
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

  // A draining output never blocks the input side.
  a_ready_when_drain: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input stalled while output drains");

  // An empty output register never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output is empty");

  // Reset leaves no result and an open input.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (!m_tvalid && s_tready))
    else $error("pipeline not empty after reset");

endmodule

bind packet_seq_replay_window_top psrw_checker u_psrw_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: verif/tb_packet_seq_replay_window_top.sv
// Self-checking testbench for the packet sequence replay window tracker.
`timescale 1ns / 100ps

module tb_packet_seq_replay_window_top;
  import psrw_pkg::*;

  // One queued stimulus item plus its pacing controls.
  typedef struct {
    logic        cmd;
    logic [15:0] wire_seq;
    bit          steady;  // offer without random gaps
    bit          drain;   // hold until every pending result has come back
  } stim_t;

  localparam int unsigned WINDOW      = 32;
  localparam int unsigned RANDOM_PKTS = 650;
  localparam int unsigned MAX_PRINTS  = 30;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [15:0]  s_tdata = '0;
  logic [0:0]   s_tuser = CMD_PACKET;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic [0:0]   m_tuser;

  // Items waiting to be driven and acks waiting to be seen.
  stim_t   pkt_queue[$];
  result_t ack_queue[$];

  // Tracker state as predicted by the testbench.
  bit                    trk_seen;
  logic [FULL_SEQ_W-1:0] trk_top;
  logic [WINDOW-1:0]     trk_window;

  int unsigned total_items;
  int unsigned items_sent;
  int unsigned clears_sent;
  int unsigned results_seen;
  int unsigned fresh_seen;
  int unsigned error_count;
  int unsigned stall_left;
  bit          stall_done;

  packet_seq_replay_window_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Prints one mismatch line (up to a cap) and counts it.
  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // Predicts the ack for one input item and advances the tracker state.
  function automatic result_t track_packet(input logic cmd, input logic [15:0] wire_seq);
    result_t               res;
    logic [FULL_SEQ_W-1:0] cand;
    logic [FULL_SEQ_W-1:0] gap;
    logic [FULL_SEQ_W-1:0] back;
    logic [WINDOW-1:0]     bit_pos;
    bit                    fresh;
    fresh = 1'b0;
    cand  = '0;
    if (cmd == CMD_CLEAR) begin
      trk_seen   = 1'b0;
      trk_top    = '0;
      trk_window = '0;
    end else if (!trk_seen) begin
      // First packet after a clear takes the wire value as is.
      cand       = {48'd0, wire_seq};
      trk_seen   = 1'b1;
      trk_top    = cand;
      trk_window = '0;
      fresh      = 1'b1;
    end else begin
      // Pick the 64-bit counter nearest to the current highest sequence.
      cand = {trk_top[FULL_SEQ_W-1:16], wire_seq};
      if (cand + SEQ_HALF < trk_top) begin
        cand = cand + SEQ_SPAN;
      end else if (cand > trk_top + SEQ_HALF && cand >= SEQ_SPAN) begin
        cand = cand - SEQ_SPAN;
      end
      if (cand > trk_top) begin
        // Newer packet: slide the window and mark the old highest.
        gap = cand - trk_top;
        if (gap >= WINDOW) begin
          trk_window = '0;
        end else begin
          trk_window = trk_window << gap;
        end
        if (gap <= WINDOW) begin
          trk_window = trk_window | (WINDOW'(1) << (gap - 1));
        end
        trk_top = cand;
        fresh   = 1'b1;
      end else begin
        // Older packet: accept only if inside the window and not yet seen.
        back = trk_top - cand;
        if (back != 0 && back <= WINDOW) begin
          bit_pos    = WINDOW'(1) << (back - 1);
          fresh      = ((trk_window & bit_pos) == '0);
          trk_window = trk_window | bit_pos;
        end
      end
    end
    res.full_seq = cand;
    res.is_new   = fresh;
    res.ack_seq  = trk_top[15:0];
    res.ack_mask = trk_window[ACK_MASK_W-1:0];
    return res;
  endfunction

  task automatic add_item(input logic cmd, input logic [15:0] wire_seq,
                          input bit steady = 1'b0, input bit drain = 1'b0);
    stim_t item;
    item.cmd      = cmd;
    item.wire_seq = wire_seq;
    item.steady   = steady;
    item.drain    = drain;
    pkt_queue.insert(pkt_queue.size(), item);
  endtask

  // Sender: predicts each accepted transfer and offers the next queued item.
  always @(posedge clk) begin
    stim_t nxt;
    bit    go;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        ack_queue.insert(ack_queue.size(), track_packet(s_tuser[0], s_tdata));
        if (s_tuser[0] == CMD_CLEAR) begin
          clears_sent++;
        end
        items_sent++;
      end
      if (!s_tvalid || s_tready) begin
        go = 1'b0;
        if (pkt_queue.size() != 0) begin
          nxt = pkt_queue[0];
          go  = 1'b1;
          if (nxt.drain && ack_queue.size() != 0) begin
            go = 1'b0;
          end
          if (!nxt.steady && $urandom_range(0, 99) < 25) begin
            go = 1'b0;
          end
        end
        if (go) begin
          pkt_queue.delete(0);
          s_tvalid <= 1'b1;
          s_tdata  <= nxt.wire_seq;
          s_tuser  <= nxt.cmd;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver ready: random idling, one long hold-off and one stretch always ready.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!stall_done && results_seen >= 100) begin
      stall_done <= 1'b1;
      stall_left <= 80;
      m_tready   <= 1'b0;
    end else if (results_seen >= 200 && results_seen < 320) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= 25);
    end
  end

  // Monitor: compares every result transfer with the oldest predicted ack.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.full_seq = m_tdata[63:0];
      got.ack_seq  = m_tdata[79:64];
      got.ack_mask = m_tdata[111:80];
      got.is_new   = m_tuser[0];
      if (ack_queue.size() == 0) begin
        report_error($sformatf("unexpected result, full_seq 0x%h", got.full_seq));
      end else begin
        want = ack_queue[0];
        ack_queue.delete(0);
        if (got.full_seq !== want.full_seq) begin
          report_error($sformatf("full_seq 0x%h, expected 0x%h", got.full_seq, want.full_seq));
        end
        if (got.is_new !== want.is_new) begin
          report_error($sformatf("is_new %b, expected %b (full_seq 0x%h)",
                                 got.is_new, want.is_new, want.full_seq));
        end
        if (got.ack_seq !== want.ack_seq) begin
          report_error($sformatf("ack_seq 0x%h, expected 0x%h", got.ack_seq, want.ack_seq));
        end
        if (got.ack_mask !== want.ack_mask) begin
          report_error($sformatf("ack_mask 0x%h, expected 0x%h", got.ack_mask, want.ack_mask));
        end
        if (want.is_new) begin
          fresh_seen <= fresh_seen + 1;
        end
      end
      results_seen <= results_seen + 1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [FULL_SEQ_W-1:0] tx_ctr;
    int unsigned           pick;
    logic [15:0]           wire_val;
    logic                  cmd;

    // Directed: first packet, duplicates, wrap in both directions, window edges, clears.
    add_item(CMD_PACKET, 16'hFFF0);
    add_item(CMD_PACKET, 16'hFFF0);
    add_item(CMD_PACKET, 16'hFFF1);
    add_item(CMD_PACKET, 16'hFFEF);
    add_item(CMD_PACKET, 16'hFFEF);
    add_item(CMD_PACKET, 16'h0005);
    add_item(CMD_PACKET, 16'hFFF8);
    add_item(CMD_PACKET, 16'h8005);
    add_item(CMD_PACKET, 16'h0005);
    add_item(CMD_PACKET, 16'h8025);
    add_item(CMD_PACKET, 16'h8005);
    add_item(CMD_PACKET, 16'h8004);
    add_item(CMD_PACKET, 16'h8046);
    add_item(CMD_CLEAR,  16'hFFFF);
    add_item(CMD_PACKET, 16'h0000);
    add_item(CMD_PACKET, 16'hFFFF);
    add_item(CMD_CLEAR,  16'h0000);
    add_item(CMD_PACKET, 16'h0010);
    add_item(CMD_PACKET, 16'hFFF0);
    add_item(CMD_PACKET, 16'h5555);
    add_item(CMD_PACKET, 16'hAAAA);
    add_item(CMD_CLEAR,  16'hAAAA);

    // Random: mostly an in-order sender with reordering, jumps, noise and clears.
    tx_ctr = 64'($urandom_range(0, 65535));
    for (int i = 0; i < RANDOM_PKTS; i++) begin
      pick = $urandom_range(0, 99);
      cmd  = CMD_PACKET;
      if (pick < 55) begin
        tx_ctr   = tx_ctr + 1;
        wire_val = tx_ctr[15:0];
      end else if (pick < 70) begin
        wire_val = 16'(tx_ctr - $urandom_range(0, 40));
      end else if (pick < 80) begin
        tx_ctr   = tx_ctr + $urandom_range(2, 40);
        wire_val = tx_ctr[15:0];
      end else if (pick < 88) begin
        tx_ctr   = tx_ctr + $urandom_range(41, 16'h7FFF);
        wire_val = tx_ctr[15:0];
      end else if (pick < 96) begin
        wire_val = 16'($urandom_range(0, 65535));
      end else begin
        cmd      = CMD_CLEAR;
        wire_val = 16'($urandom_range(0, 65535));
        tx_ctr   = 64'($urandom_range(0, 65535));
      end
      add_item(cmd, wire_val, (i >= 200 && i < 320), (i == 0 || i == 450));
    end
    total_items = pkt_queue.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (items_sent == total_items);
    while (ack_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (6) @(posedge clk);

    $display("Sent %0d items (%0d clears); %0d results checked, %0d flagged new.",
             items_sent, clears_sent, results_seen, fresh_seen);
    $display("Final tracked highest sequence 0x%h, %0d mismatches.", trk_top, error_count);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog: well beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Timeout: %0d of %0d items sent, %0d results pending.",
             items_sent, total_items, ack_queue.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
